>>> design/partition_table_reader_top_assert.svh
// Assertion macros for the partition table reader.
// Uses clk_i and rst_ni of the module that includes this header.
`ifndef PARTITION_TABLE_READER_TOP_ASSERT_SVH
`define PARTITION_TABLE_READER_TOP_ASSERT_SVH

// Checks that cons holds in the same cycle as ante.
`define PTR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that cons holds in the cycle after ante.
`define PTR_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/ptr_pkg.sv
// Package of the partition table reader: result codes, MD5 tables and the result type.
// Depends on nothing; used by the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package ptr_pkg;

  localparam int unsigned MAX_ENTRIES = 95;

  localparam logic [2:0] KIND_ENTRY    = 3'd0;
  localparam logic [2:0] KIND_DONE     = 3'd1;
  localparam logic [2:0] KIND_BAD      = 3'd2;
  localparam logic [2:0] KIND_MISMATCH = 3'd3;
  localparam logic [2:0] KIND_TOO_MANY = 3'd4;

  localparam logic [7:0] MAGIC_DIGEST = 8'hEB;
  localparam logic [7:0] MAGIC_ENTRY0 = 8'hAA;
  localparam logic [7:0] MAGIC_ENTRY1 = 8'h50;

  localparam logic [31:0] MD5_H0 = 32'h67452301;
  localparam logic [31:0] MD5_H1 = 32'hefcdab89;
  localparam logic [31:0] MD5_H2 = 32'h98badcfe;
  localparam logic [31:0] MD5_H3 = 32'h10325476;

  localparam logic [31:0] MD5_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] MD5_S [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [7:0]  part_type;
    logic [7:0]  part_subtype;
    logic [31:0] part_offset;
    logic [31:0] part_size;
    logic [63:0] label_low;
    logic [63:0] label_high;
    logic        is_encrypted;
    logic        is_readonly;
    logic [6:0]  entry_count;
    logic        ends_table;
  } result_t;

  function automatic result_t plain_result(logic [2:0] kind, logic [6:0] count);
    result_t r;
    r = '0;
    r.result_kind = kind;
    r.entry_count = count;
    r.ends_table  = 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/ptr_if.sv
// Channel interfaces of the partition table reader: input bytes, results, configuration.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface ptr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ptr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [7:0]  part_type;
  logic [7:0]  part_subtype;
  logic [31:0] part_offset;
  logic [31:0] part_size;
  logic [63:0] label_low;
  logic [63:0] label_high;
  logic        is_encrypted;
  logic        is_readonly;
  logic [6:0]  entry_count;
  logic        ends_table;
  modport source (output valid, output result_kind, output part_type, output part_subtype,
                  output part_offset, output part_size, output label_low, output label_high,
                  output is_encrypted, output is_readonly, output entry_count,
                  output ends_table, input ready);
  modport sink (input valid, input result_kind, input part_type, input part_subtype,
                input part_offset, input part_size, input label_low, input label_high,
                input is_encrypted, input is_readonly, input entry_count,
                input ends_table, output ready);
endinterface

interface ptr_cfg_if;
  logic valid;
  logic ready;
  logic check_digest;
  modport source (output valid, output check_digest, input ready);
  modport sink (input valid, input check_digest, output ready);
endinterface

`default_nettype wire

>>> design/partition_table_reader_top.sv
// A byte that does not complete a slot is taken in IDLE; a completed slot passes EVAL,
// then the MD5 rounds and FIN when an entry closes a 64-byte block (with CMP for a checked
// digest), then POST. Throughput: one byte per cycle inside a slot while no result waits;
// the shared MD5 round unit (states RND_A and RND_B per round, 64 rounds) stalls input.
// Reset: asynchronous, active low; clears all control state and sets check_digest to 1.
`timescale 1ns / 1ps
`default_nettype none

module partition_table_reader_top import ptr_pkg::*; (
  input  wire       clk_i,
  input  wire       rst_ni,
  ptr_in_if.sink    in_i,
  ptr_out_if.source out_o,
  ptr_cfg_if.sink   cfg_i
);

`include "partition_table_reader_top_assert.svh"

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EVAL  = 3'd1;
  localparam logic [2:0] ST_RND_A = 3'd2;
  localparam logic [2:0] ST_RND_B = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;
  localparam logic [2:0] ST_CMP   = 3'd5;
  localparam logic [2:0] ST_POST  = 3'd6;

  logic [2:0]  state_q;
  logic [4:0]  pos_q;
  logic [6:0]  total_q;
  logic [11:0] hashed_q;
  logic        halted_q;
  logic        last_q;
  logic        check_q;
  logic        fin_q;
  logic [5:0]  round_q;
  logic [31:0] chain_q [4];
  logic [31:0] a_q, b_q, c_q, d_q, t_q;
  logic        out_valid_q;
  result_t     res_q;
  logic [7:0]  slot_q [32];
  logic [31:0] pend_q [8];

  logic        in_acc;
  logic [31:0] slot_w [8];
  logic        all_ff;
  logic        is_entry;
  logic [3:0]  g;
  logic [31:0] f;
  logic [31:0] m;
  logic [31:0] len_w;
  logic [63:0] rot_dbl;
  logic        mismatch;
  logic        copy_pend;
  result_t     entry_res;

  assign in_acc    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE) && !out_valid_q;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    all_ff = 1'b1;
    for (int i = 0; i < 32; i++) begin
      all_ff = all_ff & (&slot_q[i]);
    end
    for (int w = 0; w < 8; w++) begin
      slot_w[w] = {slot_q[4*w+3], slot_q[4*w+2], slot_q[4*w+1], slot_q[4*w]};
    end
  end

  assign is_entry = (slot_q[0] == MAGIC_ENTRY0) && (slot_q[1] == MAGIC_ENTRY1);
  assign copy_pend = (state_q == ST_EVAL) && !all_ff && is_entry &&
                     (total_q < 7'(MAX_ENTRIES)) && !hashed_q[5];
  assign len_w = {17'd0, hashed_q, 3'd0};

  always_comb begin
    case (round_q[5:4])
      2'd0: begin
        f = (b_q & c_q) | (~b_q & d_q);
        g = round_q[3:0];
      end
      2'd1: begin
        f = (d_q & b_q) | (~d_q & c_q);
        g = 4'(5 * round_q[3:0] + 1);
      end
      2'd2: begin
        f = b_q ^ c_q ^ d_q;
        g = 4'(3 * round_q[3:0] + 5);
      end
      default: begin
        f = c_q ^ (b_q | ~d_q);
        g = 4'(7 * round_q[3:0]);
      end
    endcase
    if (!fin_q) begin
      m = g[3] ? slot_w[g[2:0]] : pend_q[g[2:0]];
    end else if (hashed_q[5]) begin
      if (!g[3]) begin
        m = pend_q[g[2:0]];
      end else if (g == 4'd8) begin
        m = 32'h80;
      end else if (g == 4'd14) begin
        m = len_w;
      end else begin
        m = '0;
      end
    end else begin
      if (g == 4'd0) begin
        m = 32'h80;
      end else if (g == 4'd14) begin
        m = len_w;
      end else begin
        m = '0;
      end
    end
  end

  assign rot_dbl  = {t_q, t_q} << MD5_S[{round_q[5:4], round_q[1:0]}];
  assign mismatch = (a_q != slot_w[4]) || (b_q != slot_w[5]) ||
                    (c_q != slot_w[6]) || (d_q != slot_w[7]);

  always_comb begin
    entry_res = '0;
    entry_res.result_kind  = KIND_ENTRY;
    entry_res.part_type    = slot_q[2];
    entry_res.part_subtype = slot_q[3];
    entry_res.part_offset  = slot_w[1];
    entry_res.part_size    = slot_w[2];
    entry_res.label_low    = {slot_w[4], slot_w[3]};
    entry_res.label_high   = {slot_w[6], slot_w[5]};
    entry_res.is_encrypted = slot_q[28][0];
    entry_res.is_readonly  = slot_q[28][1];
    entry_res.entry_count  = 7'(total_q + 7'd1);
    entry_res.ends_table   = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && !halted_q) begin
      slot_q[pos_q] <= in_i.data_byte;
    end
    if (copy_pend) begin
      for (int w = 0; w < 8; w++) begin
        pend_q[w] <= slot_w[w];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      total_q     <= '0;
      hashed_q    <= '0;
      halted_q    <= 1'b0;
      last_q      <= 1'b0;
      check_q     <= 1'b1;
      fin_q       <= 1'b0;
      round_q     <= '0;
      chain_q     <= '{MD5_H0, MD5_H1, MD5_H2, MD5_H3};
      a_q         <= '0;
      b_q         <= '0;
      c_q         <= '0;
      d_q         <= '0;
      t_q         <= '0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (cfg_i.valid) begin
        check_q <= cfg_i.check_digest;
      end
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            last_q <= in_i.last_byte;
            if (halted_q) begin
              if (in_i.last_byte) begin
                state_q <= ST_POST;
              end
            end else if (pos_q == 5'd31) begin
              pos_q   <= '0;
              state_q <= ST_EVAL;
            end else begin
              pos_q <= pos_q + 5'd1;
              if (in_i.last_byte) begin
                state_q <= ST_POST;
              end
            end
          end
        end
        ST_EVAL: begin
          state_q <= ST_POST;
          if (all_ff) begin
            res_q       <= plain_result(KIND_DONE, total_q);
            out_valid_q <= 1'b1;
            halted_q    <= 1'b1;
          end else if (slot_q[0] == MAGIC_DIGEST && slot_q[1] == MAGIC_DIGEST) begin
            if (check_q) begin
              fin_q   <= 1'b1;
              round_q <= '0;
              a_q     <= chain_q[0];
              b_q     <= chain_q[1];
              c_q     <= chain_q[2];
              d_q     <= chain_q[3];
              state_q <= ST_RND_A;
            end
          end else if (!is_entry) begin
            res_q       <= plain_result(KIND_BAD, total_q);
            out_valid_q <= 1'b1;
            halted_q    <= 1'b1;
          end else if (total_q >= 7'(MAX_ENTRIES)) begin
            res_q       <= plain_result(KIND_TOO_MANY, total_q);
            out_valid_q <= 1'b1;
            halted_q    <= 1'b1;
          end else begin
            total_q     <= total_q + 7'd1;
            res_q       <= entry_res;
            out_valid_q <= 1'b1;
            hashed_q    <= hashed_q + 12'd32;
            if (hashed_q[5]) begin
              fin_q   <= 1'b0;
              round_q <= '0;
              a_q     <= chain_q[0];
              b_q     <= chain_q[1];
              c_q     <= chain_q[2];
              d_q     <= chain_q[3];
              state_q <= ST_RND_A;
            end
          end
        end
        ST_RND_A: begin
          t_q     <= f + a_q + MD5_K[round_q] + m;
          state_q <= ST_RND_B;
        end
        ST_RND_B: begin
          a_q     <= d_q;
          d_q     <= c_q;
          c_q     <= b_q;
          b_q     <= b_q + rot_dbl[63:32];
          round_q <= round_q + 6'd1;
          state_q <= (round_q == 6'd63) ? ST_FIN : ST_RND_A;
        end
        ST_FIN: begin
          if (fin_q) begin
            a_q     <= chain_q[0] + a_q;
            b_q     <= chain_q[1] + b_q;
            c_q     <= chain_q[2] + c_q;
            d_q     <= chain_q[3] + d_q;
            state_q <= ST_CMP;
          end else begin
            chain_q <= '{chain_q[0] + a_q, chain_q[1] + b_q,
                         chain_q[2] + c_q, chain_q[3] + d_q};
            state_q <= ST_POST;
          end
        end
        ST_CMP: begin
          if (mismatch) begin
            res_q       <= plain_result(KIND_MISMATCH, total_q);
            out_valid_q <= 1'b1;
            halted_q    <= 1'b1;
          end
          state_q <= ST_POST;
        end
        ST_POST: begin
          if (!last_q) begin
            state_q <= ST_IDLE;
          end else if (halted_q || !out_valid_q) begin
            if (!halted_q) begin
              res_q       <= plain_result(KIND_DONE, total_q);
              out_valid_q <= 1'b1;
            end
            pos_q    <= '0;
            total_q  <= '0;
            hashed_q <= '0;
            halted_q <= 1'b0;
            chain_q  <= '{MD5_H0, MD5_H1, MD5_H2, MD5_H3};
            state_q  <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_kind  = res_q.result_kind;
  assign out_o.part_type    = res_q.part_type;
  assign out_o.part_subtype = res_q.part_subtype;
  assign out_o.part_offset  = res_q.part_offset;
  assign out_o.part_size    = res_q.part_size;
  assign out_o.label_low    = res_q.label_low;
  assign out_o.label_high   = res_q.label_high;
  assign out_o.is_encrypted = res_q.is_encrypted;
  assign out_o.is_readonly  = res_q.is_readonly;
  assign out_o.entry_count  = res_q.entry_count;
  assign out_o.ends_table   = res_q.ends_table;

  `PTR_ASSERT_IMP(a_err_ends, out_valid_q && res_q.result_kind != KIND_ENTRY,
                  res_q.ends_table, "A non-entry result must end the table.")
  `PTR_ASSERT_IMP(a_total_max, 1'b1, total_q <= 7'(MAX_ENTRIES),
                  "The entry count exceeds its maximum.")
  `PTR_ASSERT_NXT(a_halt_quiet, in_acc && halted_q, !out_valid_q,
                  "A byte dropped after a stop produced a result.")
  `PTR_ASSERT_IMP(a_busy_hash, state_q == ST_RND_A || state_q == ST_RND_B,
                  !in_i.ready, "A byte was offered as accepted while hashing.")

endmodule

`default_nettype wire

>>> tb/partition_table_reader_top_tb.sv
// Self-checking testbench of partition_table_reader_top: image bytes in, entry and status
// results out, predicted by a scoreboard class with its own MD5. Depends on ptr_pkg and
// the channel interfaces ptr_in_if, ptr_out_if and ptr_cfg_if.
`timescale 1ns / 1ps
`default_nettype none

module partition_table_reader_top_tb;
  import ptr_pkg::*;

  localparam int STALL_LIMIT = 6000;
  localparam int DRAIN_CYCLES = 300;

  class table_scoreboard;
    result_t     expected [$];
    int          errors;
    logic        check_on;
    logic [7:0]  slot [32];
    logic [7:0]  half_block [32];
    logic [4:0]  position;
    logic [6:0]  total;
    logic [31:0] chain [4];
    logic [11:0] hashed;
    logic        halted;

    function new();
      errors = 0;
      check_on = 1'b1;
      clear();
    endfunction

    function void clear();
      foreach (slot[i]) slot[i] = '0;
      foreach (half_block[i]) half_block[i] = '0;
      position = '0;
      total = '0;
      chain[0] = MD5_H0;
      chain[1] = MD5_H1;
      chain[2] = MD5_H2;
      chain[3] = MD5_H3;
      hashed = '0;
      halted = 1'b0;
    endfunction

    function void md5_block(inout logic [31:0] h [4], input logic [7:0] blk [64]);
      logic [31:0] m [16];
      logic [31:0] a, b, c, d, f, t;
      int g;
      int s;
      for (int i = 0; i < 16; i++)
        m[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
      a = h[0];
      b = h[1];
      c = h[2];
      d = h[3];
      for (int i = 0; i < 64; i++) begin
        if (i < 16) begin
          f = (b & c) | (~b & d);
          g = i;
        end else if (i < 32) begin
          f = (d & b) | (~d & c);
          g = (5 * i + 1) % 16;
        end else if (i < 48) begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end else begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
        t = f + a + MD5_K[i] + m[g];
        s = int'(MD5_S[((i / 16) * 4) + (i % 4)]);
        a = d;
        d = c;
        c = b;
        b = b + ((t << s) | (t >> (32 - s)));
      end
      h[0] += a;
      h[1] += b;
      h[2] += c;
      h[3] += d;
    endfunction

    function void digest_bytes(output logic [7:0] dg [16]);
      logic [31:0] h [4];
      logic [7:0]  blk [64];
      logic [63:0] bits;
      int fill;
      h = chain;
      foreach (blk[i]) blk[i] = '0;
      fill = 0;
      bits = 64'(hashed) * 8;
      if (hashed[5:0] != 0) begin
        for (int i = 0; i < 32; i++) blk[i] = half_block[i];
        fill = 32;
      end
      blk[fill] = 8'h80;
      for (int i = 0; i < 8; i++) blk[56 + i] = bits[8*i +: 8];
      md5_block(h, blk);
      for (int i = 0; i < 16; i++) dg[i] = h[i / 4][8 * (i % 4) +: 8];
    endfunction

    function void push_plain(logic [2:0] kind);
      result_t r;
      r = '0;
      r.result_kind = kind;
      r.entry_count = total;
      r.ends_table = 1'b1;
      expected.push_back(r);
    endfunction

    function void close_slot();
      logic [7:0] dg [16];
      logic [7:0] blk [64];
      logic [31:0] flags;
      result_t r;
      bit all_ff;
      bit same;
      all_ff = 1;
      foreach (slot[i]) if (slot[i] != 8'hFF) all_ff = 0;
      if (all_ff) begin
        push_plain(KIND_DONE);
        halted = 1'b1;
        return;
      end
      if (slot[0] == MAGIC_DIGEST && slot[1] == MAGIC_DIGEST) begin
        if (check_on) begin
          digest_bytes(dg);
          same = 1;
          for (int i = 0; i < 16; i++) if (dg[i] != slot[16 + i]) same = 0;
          if (!same) begin
            push_plain(KIND_MISMATCH);
            halted = 1'b1;
          end
        end
        return;
      end
      if (slot[0] != MAGIC_ENTRY0 || slot[1] != MAGIC_ENTRY1) begin
        push_plain(KIND_BAD);
        halted = 1'b1;
        return;
      end
      if (total >= MAX_ENTRIES) begin
        push_plain(KIND_TOO_MANY);
        halted = 1'b1;
        return;
      end
      total = total + 7'd1;
      r = '0;
      r.result_kind = KIND_ENTRY;
      r.part_type = slot[2];
      r.part_subtype = slot[3];
      r.part_offset = {slot[7], slot[6], slot[5], slot[4]};
      r.part_size = {slot[11], slot[10], slot[9], slot[8]};
      for (int i = 0; i < 8; i++) begin
        r.label_low[8*i +: 8] = slot[12 + i];
        r.label_high[8*i +: 8] = slot[20 + i];
      end
      flags = {slot[31], slot[30], slot[29], slot[28]};
      r.is_encrypted = flags[0];
      r.is_readonly = flags[1];
      r.entry_count = total;
      expected.push_back(r);
      if (hashed[5:0] == 0) begin
        half_block = slot;
      end else begin
        for (int i = 0; i < 32; i++) begin
          blk[i] = half_block[i];
          blk[32 + i] = slot[i];
        end
        md5_block(chain, blk);
      end
      hashed = hashed + 12'd32;
    endfunction

    function void note_byte(logic [7:0] data, logic last);
      if (!halted) begin
        slot[position] = data;
        if (position == 5'd31) begin
          position = '0;
          close_slot();
        end else begin
          position = position + 5'd1;
        end
        if (last && !halted) push_plain(KIND_DONE);
      end
      if (last) clear();
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
      errors++;
    endtask

    task compare(string what, logic [63:0] got, logic [63:0] want);
      if (got !== want) report(what, got, want);
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected.size() == 0) begin
        report("unexpected result, kind", 64'(got.result_kind), '0);
        return;
      end
      want = expected.pop_front();
      compare("result_kind", 64'(got.result_kind), 64'(want.result_kind));
      compare("part_type", 64'(got.part_type), 64'(want.part_type));
      compare("part_subtype", 64'(got.part_subtype), 64'(want.part_subtype));
      compare("part_offset", 64'(got.part_offset), 64'(want.part_offset));
      compare("part_size", 64'(got.part_size), 64'(want.part_size));
      compare("label_low", got.label_low, want.label_low);
      compare("label_high", got.label_high, want.label_high);
      compare("is_encrypted", 64'(got.is_encrypted), 64'(want.is_encrypted));
      compare("is_readonly", 64'(got.is_readonly), 64'(want.is_readonly));
      compare("entry_count", 64'(got.entry_count), 64'(want.entry_count));
      compare("ends_table", 64'(got.ends_table), 64'(want.ends_table));
    endtask
  endclass

  typedef enum int {
    TAIL_NONE, TAIL_STOP, TAIL_PARTIAL, TAIL_BAD, TAIL_BAD_JUNK, TAIL_STOP_JUNK
  } tail_e;

  typedef enum int {DIGEST_NONE, DIGEST_GOOD, DIGEST_WRONG} digest_e;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_e;

  logic clk_i;
  logic rst_ni;
  int   in_idle_pct;
  int   out_idle_pct;
  int   hold_cycles;
  int   quiet_cycles = 0;
  table_scoreboard sb;

  ptr_in_if  in_if ();
  ptr_out_if out_if ();
  ptr_cfg_if cfg_if ();

  partition_table_reader_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source),
    .cfg_i  (cfg_if.sink)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task send_byte(logic [7:0] data, logic last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data_byte <= data;
    in_if.last_byte <= last;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_byte(data, last);
  endtask

  task wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task write_check(logic value);
    wait_drained();
    cfg_if.valid <= 1'b1;
    cfg_if.check_digest <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.check_on = value;
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic add_entry(ref logic [7:0] img [$], input fill_e fill);
    img.push_back(MAGIC_ENTRY0);
    img.push_back(MAGIC_ENTRY1);
    for (int i = 2; i < 32; i++) begin
      case (fill)
        FILL_ZERO: img.push_back(8'h00);
        FILL_ONES: img.push_back(8'hFF);
        default: img.push_back(8'($urandom));
      endcase
    end
  endtask

  task automatic add_bad_slot(ref logic [7:0] img [$]);
    logic [7:0] first;
    case ($urandom_range(3))
      0: begin
        img.push_back(MAGIC_ENTRY0);
        img.push_back(MAGIC_ENTRY1 ^ 8'($urandom_range(1, 255)));
      end
      1: begin
        img.push_back(MAGIC_DIGEST);
        img.push_back(MAGIC_DIGEST ^ 8'($urandom_range(1, 255)));
      end
      2: begin
        for (int i = 0; i < 31; i++) img.push_back(8'hFF);
        img.push_back(8'($urandom_range(0, 254)));
        return;
      end
      default: begin
        do first = 8'($urandom); while (first == MAGIC_ENTRY0 || first == MAGIC_DIGEST);
        img.push_back(first);
        img.push_back(8'($urandom));
      end
    endcase
    for (int i = 2; i < 32; i++) img.push_back(8'($urandom));
  endtask

  task automatic send_image(int entries, fill_e fill, digest_e dmode, tail_e tail);
    logic [7:0] img [$];
    logic [7:0] dg [16];
    int digest_at;
    int junk;
    digest_at = -1;
    for (int n = 0; n < entries; n++) add_entry(img, fill);
    if (dmode != DIGEST_NONE) begin
      img.push_back(MAGIC_DIGEST);
      img.push_back(MAGIC_DIGEST);
      for (int i = 2; i < 16; i++) img.push_back(8'($urandom));
      digest_at = img.size();
      for (int i = 16; i < 32; i++) img.push_back(8'h00);
    end
    case (tail)
      TAIL_STOP, TAIL_STOP_JUNK: for (int i = 0; i < 32; i++) img.push_back(8'hFF);
      TAIL_PARTIAL: begin
        junk = $urandom_range(1, 31);
        for (int i = 0; i < junk; i++) img.push_back(8'($urandom));
      end
      TAIL_BAD, TAIL_BAD_JUNK: add_bad_slot(img);
      default: ;
    endcase
    if (tail == TAIL_BAD_JUNK || tail == TAIL_STOP_JUNK) begin
      junk = $urandom_range(1, 40);
      for (int i = 0; i < junk; i++) img.push_back(8'($urandom));
    end
    if (img.size() == 0) img.push_back(8'($urandom));
    for (int i = 0; i < img.size(); i++) begin
      if (i == digest_at) begin
        sb.digest_bytes(dg);
        if (dmode == DIGEST_WRONG) dg[$urandom_range(15)] ^= 8'(1 << $urandom_range(7));
        for (int k = 0; k < 16; k++) img[digest_at + k] = dg[k];
      end
      send_byte(img[i], i == img.size() - 1);
    end
  endtask

  task random_image();
    int pick;
    int entries;
    pick = $urandom_range(99);
    entries = ($urandom_range(9) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 4);
    if (pick < 12) begin
      send_image(0, FILL_RANDOM, DIGEST_NONE, tail_e'($urandom_range(2, 4)));
    end else begin
      send_image(entries, FILL_RANDOM,
                 ($urandom_range(9) < 6) ? DIGEST_GOOD :
                   (($urandom_range(1) == 1) ? DIGEST_WRONG : DIGEST_NONE),
                 tail_e'($urandom_range(0, 5)));
    end
  endtask

  task random_phase(int bytes, int in_pct, int out_pct);
    int start;
    in_idle_pct = in_pct;
    out_idle_pct = out_pct;
    start = quiet_cycles;
    while (quiet_cycles - start < bytes) begin
      random_image();
      if ($urandom_range(7) == 0) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
        random_image();
        in_idle_pct = in_pct;
        out_idle_pct = out_pct;
      end
    end
  endtask

  // Counts accepted input bytes for the random phases.
  always @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    sb = new();
    in_idle_pct = 0;
    out_idle_pct = 0;
    hold_cycles = 0;
    rst_ni <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.data_byte <= '0;
    in_if.last_byte <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.check_digest <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_image(2, FILL_ZERO, DIGEST_GOOD, TAIL_STOP);
    send_image(1, FILL_ONES, DIGEST_NONE, TAIL_NONE);
    send_image(0, FILL_RANDOM, DIGEST_NONE, TAIL_BAD_JUNK);
    send_image(1, FILL_RANDOM, DIGEST_WRONG, TAIL_PARTIAL);
    send_image(0, FILL_RANDOM, DIGEST_GOOD, TAIL_NONE);
    send_image(3, FILL_RANDOM, DIGEST_GOOD, TAIL_PARTIAL);
    write_check(1'b0);
    send_image(1, FILL_RANDOM, DIGEST_WRONG, TAIL_STOP_JUNK);
    write_check(1'b1);

    random_phase(130, 24, 48);
    write_check(1'b0);
    random_phase(130, 48, 24);
    write_check(1'b1);
    hold_cycles = 500;
    in_idle_pct = 0;
    out_idle_pct = 0;
    send_image(6, FILL_RANDOM, DIGEST_GOOD, TAIL_STOP);
    wait_drained();
    random_phase(130, 0, 0);

    wait_drained();
    if (sb.errors == 0 && sb.expected.size() == 0) begin
      $display("partition_table_reader_top_tb: done, clean");
    end else begin
      $display("partition_table_reader_top_tb: done, errors");
    end
    $finish;
  end

  initial begin
    result_t got;
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_cycles > 0) begin
        hold_cycles = hold_cycles - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= out_idle_pct);
      end
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        got.result_kind = out_if.result_kind;
        got.part_type = out_if.part_type;
        got.part_subtype = out_if.part_subtype;
        got.part_offset = out_if.part_offset;
        got.part_size = out_if.part_size;
        got.label_low = out_if.label_low;
        got.label_high = out_if.label_high;
        got.is_encrypted = out_if.is_encrypted;
        got.is_readonly = out_if.is_readonly;
        got.entry_count = out_if.entry_count;
        got.ends_table = out_if.ends_table;
        sb.check_result(got);
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle = 0;
      end else begin
        idle = idle + 1;
      end
      if (idle >= STALL_LIMIT) begin
        $display("partition_table_reader_top_tb: done, errors");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire
